// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define OSTT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ostt assertion failed");

// condition that must hold in the cycle after a trigger
`define OSTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ostt assertion failed");

`endif

// ===== rtl/core/ostt_pkg.sv =====
// shared types and constants of the os tick timer
package ostt_pkg;

    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_TICK  = 3'd1;
    localparam logic [2:0] OP_SLEEP = 3'd2;
    localparam logic [2:0] OP_QUERY = 3'd3;
    localparam logic [2:0] OP_WAKE  = 3'd4;

    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_PERIOD   = 2'd0;
    localparam logic [1:0] REG_HZ       = 2'd1;
    localparam logic [1:0] REG_SUPPRESS = 2'd2;

    localparam logic [31:0] PERIOD_RST = 32'd50000;
    localparam logic [31:0] HZ_RST     = 32'd50000000;

    // always-on clock is 32768 Hz
    localparam int AON_SHIFT = 15;
    localparam int DIV_CNT_W = 6;

    typedef struct packed {
        logic load_in;
        logic arm_count;
        logic mark_spurious;
        logic div_ld_irq;
        logic enter_sleep;
        logic mul_slept;
        logic acc_sample;
        logic div_ld_wake;
        logic div_step;
        logic post_irq;
        logic post_sample;
        logic post_wake;
        logic mul_ticks;
        logic add_ticks;
        logic out_load;
    } ostt_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       below;
        logic       suppress;
        logic       div_last;
    } ostt_sts_t;

endpackage

// ===== rtl/core/ostt_in_if.sv =====
// input transaction channel
interface ostt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [63:0] counter_value;
    logic [31:0] aon_ticks;

    modport source (output valid, output operation, output counter_value,
                    output aon_ticks, input ready);
    modport sink (input valid, input operation, input counter_value,
                  input aon_ticks, output ready);
endinterface

// ===== rtl/core/ostt_out_if.sv =====
// result transaction channel
interface ostt_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [31:0] ticks;
    logic [63:0] compare_value;
    logic        timer_enabled;

    modport source (output valid, output status, output ticks,
                    output compare_value, output timer_enabled, input ready);
    modport sink (input valid, input status, input ticks,
                  input compare_value, input timer_enabled, output ready);
endinterface

// ===== rtl/core/ostt_dp.sv =====
// timer datapath: state, multiplier, serial divider, result registers
module ostt_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  ostt_pkg::ostt_cmd_t cmd,
    output ostt_pkg::ostt_sts_t sts,
    input  logic [31:0]         period,
    input  logic [31:0]         hz,
    input  logic                suppress,
    input  logic [2:0]          operation,
    input  logic [63:0]         counter_value,
    input  logic [31:0]         aon_ticks,
    output logic                status,
    output logic [31:0]         ticks,
    output logic [63:0]         compare_value,
    output logic                timer_enabled
);

    logic [2:0]  op_reg;
    logic [63:0] count_reg;
    logic [31:0] aon_reg;
    logic [63:0] compare_reg;
    logic        enable_reg;
    logic [31:0] start_aon_reg;
    logic [63:0] pending_reg;
    logic [63:0] s_counter_reg;
    logic [63:0] s_cycles_reg;
    logic        status_reg;
    logic [31:0] ticks_reg;
    logic [63:0] prod_reg;
    logic [63:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [ostt_pkg::DIV_CNT_W-1:0] cnt_reg;

    logic [31:0] period_eff;
    logic [63:0] period64;
    logic [63:0] sample_sum;
    logic [63:0] dvd_next;
    logic [32:0] trial;
    logic        fits;

    assign period_eff = (period == 32'd0) ? 32'd1 : period;
    assign period64   = {32'd0, period_eff};
    assign sample_sum = pending_reg + {{ostt_pkg::AON_SHIFT{1'b0}},
                                       prod_reg[63:ostt_pkg::AON_SHIFT]};
    assign trial = {rem_reg, dvd_reg[63]};
    assign fits  = trial >= {1'b0, period_eff};

    always_comb
    begin
        dvd_next = sample_sum;
        if (cmd.div_ld_irq)
        begin
            dvd_next = count_reg - compare_reg;
        end
        else if (cmd.div_ld_wake)
        begin
            dvd_next = s_cycles_reg;
        end
    end

    assign sts.op       = op_reg;
    assign sts.below    = count_reg < compare_reg;
    assign sts.suppress = suppress;
    assign sts.div_last = cnt_reg == {ostt_pkg::DIV_CNT_W{1'b1}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_reg   <= '0;
            enable_reg    <= 1'b0;
            start_aon_reg <= '0;
            pending_reg   <= '0;
            s_counter_reg <= '0;
            s_cycles_reg  <= '0;
        end
        else
        begin
            if (cmd.arm_count)
            begin
                compare_reg <= count_reg + period64;
                enable_reg  <= 1'b1;
            end
            if (cmd.add_ticks)
            begin
                compare_reg <= compare_reg + prod_reg;
            end
            if (cmd.post_wake)
            begin
                compare_reg <= s_counter_reg + period64 - {32'd0, rem_reg};
                enable_reg  <= 1'b1;
            end
            if (cmd.enter_sleep)
            begin
                enable_reg    <= 1'b0;
                start_aon_reg <= aon_reg;
                pending_reg   <= count_reg - (compare_reg - period64);
            end
            if (cmd.acc_sample)
            begin
                s_cycles_reg  <= sample_sum;
                s_counter_reg <= count_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg     <= operation;
            count_reg  <= counter_value;
            aon_reg    <= aon_ticks;
            status_reg <= 1'b0;
            ticks_reg  <= '0;
        end
        if (cmd.mark_spurious)
        begin
            status_reg <= 1'b1;
        end
        if (cmd.post_irq)
        begin
            ticks_reg <= dvd_reg[31:0] + 32'd1;
        end
        if (cmd.post_sample)
        begin
            ticks_reg <= dvd_reg[31:0];
        end
        if (cmd.mul_slept)
        begin
            prod_reg <= {32'd0, aon_reg - start_aon_reg} * {32'd0, hz};
        end
        if (cmd.mul_ticks)
        begin
            prod_reg <= {32'd0, ticks_reg} * period64;
        end
        // restoring divider, one quotient bit per cycle
        if (cmd.div_ld_irq || cmd.acc_sample || cmd.div_ld_wake)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[62:0], fits};
            rem_reg <= fits ? 32'(trial - {1'b0, period_eff}) : trial[31:0];
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            status        <= status_reg;
            ticks         <= ticks_reg;
            compare_value <= compare_reg;
            timer_enabled <= enable_reg;
        end
    end

endmodule

// ===== rtl/core/ostt_ctrl.sv =====
// sequencing state machine of the os tick timer
module ostt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  ostt_pkg::ostt_sts_t sts,
    output ostt_pkg::ostt_cmd_t cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_ACC  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_POST = 4'd5;
    localparam logic [3:0] S_TMUL = 4'd6;
    localparam logic [3:0] S_TADD = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_DONE;
                case (sts.op)
                    ostt_pkg::OP_START:
                    begin
                        cmd.arm_count = 1'b1;
                    end
                    ostt_pkg::OP_TICK:
                    begin
                        if (sts.below)
                        begin
                            cmd.mark_spurious = 1'b1;
                        end
                        else
                        begin
                            cmd.div_ld_irq = 1'b1;
                            state_next     = S_DIV;
                        end
                    end
                    ostt_pkg::OP_SLEEP:
                    begin
                        cmd.enter_sleep = 1'b1;
                        state_next      = S_MUL;
                    end
                    ostt_pkg::OP_QUERY:
                    begin
                        state_next = S_MUL;
                    end
                    ostt_pkg::OP_WAKE:
                    begin
                        if (sts.suppress)
                        begin
                            cmd.div_ld_wake = 1'b1;
                            state_next      = S_DIV;
                        end
                        else
                        begin
                            cmd.arm_count = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_MUL:
            begin
                cmd.mul_slept = 1'b1;
                state_next    = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_sample = 1'b1;
                state_next     = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                state_next = S_DONE;
                case (sts.op)
                    ostt_pkg::OP_TICK:
                    begin
                        cmd.post_irq = 1'b1;
                        state_next   = S_TMUL;
                    end
                    ostt_pkg::OP_WAKE:
                    begin
                        cmd.post_wake = 1'b1;
                    end
                    default:
                    begin
                        cmd.post_sample = 1'b1;
                    end
                endcase
            end
            S_TMUL:
            begin
                cmd.mul_ticks = 1'b1;
                state_next    = S_TADD;
            end
            S_TADD:
            begin
                cmd.add_ticks = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/os_tick_timer_with_suppression_core.sv =====
// top level of the os tick timer: config registers, controller and datapath
// start, plain wake, spurious interrupt and unused codes go from dispatch straight to the result;
// tick interrupt, sleep entry, elapsed query and suppressed wake also run the serial divider
// one transaction at a time: the next is accepted in the cycle after the result loads,
// and operations that use the 64-step serial divider take longest
// a finished result waits in the output register while the next one is taken
// reset (rst_n low, asynchronous) clears timer state and loads config defaults
`include "assert_macros.svh"

module os_tick_timer_with_suppression_core (
    input  logic                        clk,
    input  logic                        rst_n,
    ostt_in_if.sink                     item_in,
    ostt_out_if.source                  result_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ostt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // configuration registers
    logic [31:0] period_reg;
    logic [31:0] hz_reg;
    logic        suppress_reg;
    logic        cfg_wr;

    ostt_pkg::ostt_cmd_t cmd;
    ostt_pkg::ostt_sts_t sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= ostt_pkg::PERIOD_RST;
            hz_reg       <= ostt_pkg::HZ_RST;
            suppress_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                ostt_pkg::REG_PERIOD:   period_reg   <= pwdata;
                ostt_pkg::REG_HZ:       hz_reg       <= pwdata;
                ostt_pkg::REG_SUPPRESS: suppress_reg <= pwdata[0];
                default:                ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[3:2])
            ostt_pkg::REG_PERIOD:   prdata = period_reg;
            ostt_pkg::REG_HZ:       prdata = hz_reg;
            ostt_pkg::REG_SUPPRESS: prdata = {31'd0, suppress_reg};
            default:                prdata = '0;
        endcase
    end

    // sequencer: issues one command set per cycle
    ostt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_in.valid),
        .in_ready  (item_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // state, multiplier and divider
    ostt_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .period        (period_reg),
        .hz            (hz_reg),
        .suppress      (suppress_reg),
        .operation     (item_in.operation),
        .counter_value (item_in.counter_value),
        .aon_ticks     (item_in.aon_ticks),
        .status        (result_out.status),
        .ticks         (result_out.ticks),
        .compare_value (result_out.compare_value),
        .timer_enabled (result_out.timer_enabled)
    );

    // not ready in the cycle after taking a transaction
    `OSTT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, item_in.valid && item_in.ready, !item_in.ready)
    // a spurious interrupt never reports ticks
    `OSTT_ASSERT(a_spurious_no_ticks, clk, rst_n, (result_out.valid && result_out.status) |-> (result_out.ticks == 32'd0))

endmodule
